/* hw/rtl/spm_pkg.sv */
package spm_pkg;

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int TRIG_BITS = 7;
  localparam int SERIES_TERMS = 16;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_LOW_LEVEL  = 1'b0,
    REG_HIGH_LEVEL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // quarter-wave table word plus quadrant
  typedef struct packed {
    logic [TRIG_BITS-1:0] sq;
    logic [TRIG_BITS-1:0] cq;
    quad_t                quad;
  } trig_t;

  // round(127*sin) or round(127*cos) of quarter-wave step r, q62 taylor series,
  // evaluated at elaboration only
  function automatic logic [TRIG_BITS-1:0] trig127(input int phase_bits, input int r,
                                                   input logic is_sin);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  t;
    logic [63:0]  rnd;
    logic [127:0] prod;
    int           k;
    x    = (PI_Q62 >> (phase_bits - 1)) * 64'(r);
    prod = 128'(x) * 128'(x);
    x2   = prod[125:62];
    term = is_sin ? x : Q62_ONE;
    sum  = term;
    k    = is_sin ? 1 : 0;
    for (int i = 0; i < SERIES_TERMS; i++) begin
      prod = 128'(term) * 128'(x2);
      term = prod[125:62] / 64'((k + 1) * (k + 2));
      k    = k + 2;
      if ((i & 1) != 0) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
    end
    t   = (sum >> 8) * 64'd127;
    rnd = (t + (64'd1 << 53)) >> 54;
    return rnd[TRIG_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/spm_regs.sv */
module spm_regs #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [spm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [spm_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic [PIXEL_BITS-1:0]          low_level,
  output logic [PIXEL_BITS-1:0]          high_level
);

  spm_pkg::reg_idx_t idx;

  assign idx    = spm_pkg::reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level  <= '0;
      high_level <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        spm_pkg::REG_LOW_LEVEL:  low_level  <= pwdata[PIXEL_BITS-1:0];
        spm_pkg::REG_HIGH_LEVEL: high_level <= pwdata[PIXEL_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      spm_pkg::REG_LOW_LEVEL:  prdata = spm_pkg::DATA_BITS'(low_level);
      spm_pkg::REG_HIGH_LEVEL: prdata = spm_pkg::DATA_BITS'(high_level);
    endcase
  end

endmodule

/* hw/rtl/spm_div_step.sv */
module spm_div_step #(
  parameter int PIXEL_BITS = 16,
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PIXEL_BITS-1:0] rem_in,
  input  logic [PIXEL_BITS-1:0] dvs_in,
  input  logic [PHASE_BITS-1:0] quo_in,
  output logic [PIXEL_BITS-1:0] rem,
  output logic [PIXEL_BITS-1:0] dvs,
  output logic [PHASE_BITS-1:0] quo
);

  logic [PIXEL_BITS:0] shifted;
  logic [PIXEL_BITS:0] trial;
  logic                take;

  // one restoring step: remainder stays below the divisor
  always_comb begin
    shifted = {rem_in, 1'b0};
    trial   = shifted - {1'b0, dvs_in};
    take    = shifted >= {1'b0, dvs_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? trial[PIXEL_BITS-1:0] : shifted[PIXEL_BITS-1:0];
      dvs <= dvs_in;
      quo <= {quo_in[PHASE_BITS-2:0], take};
    end
  end

endmodule

/* hw/rtl/spm_trig_rom.sv */
module spm_trig_rom #(
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PHASE_BITS-1:0] phase,
  output spm_pkg::trig_t        trig
);

  localparam int IDX_BITS = PHASE_BITS - 2;
  localparam int QUARTER  = 1 << IDX_BITS;

  logic [spm_pkg::TRIG_BITS-1:0] sin_rom [QUARTER];
  logic [spm_pkg::TRIG_BITS-1:0] cos_rom [QUARTER];
  logic [IDX_BITS-1:0]           idx;

  for (genvar g = 0; g < QUARTER; g++) begin : g_rom
    localparam logic [spm_pkg::TRIG_BITS-1:0] SIN_V = spm_pkg::trig127(PHASE_BITS, g, 1'b1);
    localparam logic [spm_pkg::TRIG_BITS-1:0] COS_V = spm_pkg::trig127(PHASE_BITS, g, 1'b0);
    assign sin_rom[g] = SIN_V;
    assign cos_rom[g] = COS_V;
  end

  assign idx = phase[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      trig.sq   <= sin_rom[idx];
      trig.cq   <= cos_rom[idx];
      trig.quad <= spm_pkg::quad_t'(phase[PHASE_BITS-1 -: 2]);
    end
  end

endmodule

/* hw/rtl/sine_pseudocolor_mapper.sv */
// channel  | handshake              | payload
// pix      | pix_valid / pix_stall  | pixel
// rgb      | rgb_valid / rgb_stall  | blue_out, green_out, red_out
// apb      | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// one pixel word per clock sustained while rgb_stall is low; the divider resolves
// one phase bit per stage, and the stages are front, PHASE_BITS divide steps,
// quarter-wave table, output register
// rst is synchronous: clears all stage valid bits and loads the reset levels
// each stage holds while its successor is full and stalled; bubbles collapse,
// so a pixel is still taken while a finished word waits at the output
module sine_pseudocolor_mapper #(
  parameter int PHASE_BITS = 10,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [spm_pkg::DATA_BITS-1:0] pwdata,
  output logic [spm_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  // pixel input
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic [PIXEL_BITS-1:0]         pixel,
  // color output
  output logic                          rgb_valid,
  input  logic                          rgb_stall,
  output logic [7:0]                    blue_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    red_out
);

  // stage 0 front, 1..PHASE_BITS divide, then table, then output
  localparam int TAB_STAGE = PHASE_BITS + 1;
  localparam int OUT_STAGE = PHASE_BITS + 2;
  localparam int NUM_STAGE = PHASE_BITS + 3;

  logic [PIXEL_BITS-1:0] low_level;
  logic [PIXEL_BITS-1:0] high_level;

  logic [NUM_STAGE-1:0]  vld;
  logic [NUM_STAGE:0]    rdy;

  logic [PIXEL_BITS-1:0] rem [PHASE_BITS];
  logic [PIXEL_BITS-1:0] dvs [PHASE_BITS];
  logic [PHASE_BITS-1:0] quo [PHASE_BITS+1];

  logic [PIXEL_BITS-1:0] span;
  logic                  span_pos;
  logic [PIXEL_BITS-1:0] d_front;

  spm_pkg::trig_t        trig;
  logic signed [8:0]     s_val;
  logic signed [8:0]     c_val;
  logic signed [8:0]     sq_s;
  logic signed [8:0]     cq_s;
  logic [8:0]            blue9;
  logic [8:0]            green9;
  logic [8:0]            red9;

  spm_regs #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .low_level (low_level),
    .high_level(high_level)
  );

  // ---------------- stage control ----------------
  // a stage loads when it is empty or its successor moves on
  assign rdy[NUM_STAGE] = !rgb_stall;
  for (genvar i = 0; i < NUM_STAGE; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end

  assign pix_stall = !rdy[0];
  assign rgb_valid = vld[OUT_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int i = 1; i < NUM_STAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------- front: offset and clamp ----------------
  // empty or inverted range forces offset 0 over divisor 1, so phase 0
  always_comb begin
    span     = high_level - low_level;
    span_pos = high_level > low_level;
    priority if (!span_pos) begin
      d_front = '0;
    end else if (pixel >= high_level) begin
      d_front = span - PIXEL_BITS'(1);
    end else if (pixel > low_level) begin
      d_front = pixel - low_level;
    end else begin
      d_front = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= d_front;
      dvs[0] <= span_pos ? span : PIXEL_BITS'(1);
    end
  end

  // ---------------- phase divider: d * 2^PHASE_BITS / span ----------------
  assign quo[0] = '0;

  for (genvar i = 0; i < PHASE_BITS; i++) begin : g_div
    if (i < PHASE_BITS - 1) begin : g_mid
      spm_div_step #(
        .PIXEL_BITS(PIXEL_BITS),
        .PHASE_BITS(PHASE_BITS)
      ) u_step (
        .clk   (clk),
        .en    (rdy[i+1]),
        .rem_in(rem[i]),
        .dvs_in(dvs[i]),
        .quo_in(quo[i]),
        .rem   (rem[i+1]),
        .dvs   (dvs[i+1]),
        .quo   (quo[i+1])
      );
    end else begin : g_last
      // final remainder and divisor are not needed past this point
      spm_div_step #(
        .PIXEL_BITS(PIXEL_BITS),
        .PHASE_BITS(PHASE_BITS)
      ) u_step (
        .clk   (clk),
        .en    (rdy[i+1]),
        .rem_in(rem[i]),
        .dvs_in(dvs[i]),
        .quo_in(quo[i]),
        .rem   (),
        .dvs   (),
        .quo   (quo[i+1])
      );
    end
  end

  // ---------------- quarter-wave table ----------------
  spm_trig_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (rdy[TAB_STAGE]),
    .phase(quo[PHASE_BITS]),
    .trig (trig)
  );

  // ---------------- quadrant fold and output ----------------
  always_comb begin
    sq_s = $signed({2'b00, trig.sq});
    cq_s = $signed({2'b00, trig.cq});
    unique case (trig.quad)
      spm_pkg::QUAD_0: begin
        s_val = sq_s;
        c_val = cq_s;
      end
      spm_pkg::QUAD_1: begin
        s_val = cq_s;
        c_val = -sq_s;
      end
      spm_pkg::QUAD_2: begin
        s_val = -sq_s;
        c_val = -cq_s;
      end
      spm_pkg::QUAD_3: begin
        s_val = -cq_s;
        c_val = sq_s;
      end
    endcase
    blue9  = 9'(9'sd128 + s_val);
    green9 = 9'(9'sd128 - c_val);
    red9   = 9'(9'sd128 - s_val);
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT_STAGE]) begin
      blue_out  <= blue9[7:0];
      green_out <= green9[7:0];
      red_out   <= red9[7:0];
    end
  end

  // ---------------- checks ----------------
  // clamp keeps the offset strictly below the divisor
  a_front_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> rem[0] < dvs[0])
    else $error("front offset not below divisor");

  // restoring step keeps the remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> rem[1] < dvs[1])
    else $error("divider remainder not below divisor");

  // color channels never reach zero
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (blue_out != 8'd0) && (green_out != 8'd0) && (red_out != 8'd0))
    else $error("color channel out of range");

endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int PHASE_BITS = 10;
  localparam int PIXEL_BITS = 16;
  localparam int LATENCY    = PHASE_BITS + 3;

  // one output word: the three color channels
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb side
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [spm_pkg::ADDR_BITS-1:0] paddr   = '0;
  logic [spm_pkg::DATA_BITS-1:0] pwdata  = '0;
  logic [spm_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  // pixel side
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  logic [PIXEL_BITS-1:0] pixel     = '0;

  // color side
  logic                  rgb_valid;
  logic                  rgb_stall = 1'b0;
  logic [7:0]            blue_out;
  logic [7:0]            green_out;
  logic [7:0]            red_out;

  // our own copy of the two level registers
  logic [15:0] low_lvl  = 16'd0;
  logic [15:0] high_lvl = 16'd65535;

  // colors still to come out of the block, oldest first
  color_t colors_due[$];

  // random idling on both sides, switched off for the last part
  logic idle_on = 1'b0;
  int   stall_left = 0;

  int     bad_words = 0;
  int     leftover  = 0;
  int     waited;
  color_t want_c;
  color_t got_c;

  always #2 clk = ~clk;

  sine_pseudocolor_mapper #(
    .PHASE_BITS(PHASE_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pixel(pixel),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .blue_out(blue_out),
    .green_out(green_out),
    .red_out(red_out)
  );

  // ---------------------------------------------------------------------------
  // color prediction in q62 fixed point
  // ---------------------------------------------------------------------------

  // (a * b) >> 62, truncated to 64 bits
  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  // taylor sum of sine (first = x, k0 = 1) or cosine (first = one, k0 = 0)
  function automatic logic [63:0] taylor_q62(logic [63:0] x2, logic [63:0] first,
                                             int unsigned k0);
    logic [63:0] term;
    logic [63:0] acc;
    int unsigned k;
    term = first;
    acc  = first;
    k    = k0;
    for (int i = 0; i < 16; i++) begin
      term = q62_product(term, x2) / 64'((k + 1) * (k + 2));
      k    = k + 2;
      // signs alternate, starting with a subtraction
      if ((i % 2) != 0) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
    end
    return acc;
  endfunction

  // 127 * v rounded half up, v in q62 between 0 and 1
  function automatic int times127_rounded(logic [63:0] v);
    logic [63:0] t;
    t = (v >> 8) * 64'd127;
    t = (t + (64'd1 << 53)) >> 54;
    return int'(t);
  endfunction

  function automatic color_t map_pixel(logic [15:0] pix);
    logic [63:0] diff;
    logic [63:0] d;
    logic [63:0] ph;
    logic [63:0] x;
    logic [63:0] x2;
    logic [PHASE_BITS-3:0] rem;
    spm_pkg::quad_t quad;
    int     sq;
    int     cq;
    int     s;
    int     c;
    color_t col;
    d  = 64'd0;
    ph = 64'd0;
    // empty or inverted window leaves the phase at zero
    if (high_lvl > low_lvl) begin
      diff = 64'(high_lvl) - 64'(low_lvl);
      if (pix > low_lvl) begin
        d = 64'(pix) - 64'(low_lvl);
      end
      // pixels at or past the high level stay on the last step
      if (d > diff - 64'd1) begin
        d = diff - 64'd1;
      end
      ph = (d << PHASE_BITS) / diff;
    end
    quad = spm_pkg::quad_t'(ph[PHASE_BITS-1 -: 2]);
    rem  = ph[PHASE_BITS-3:0];
    x    = (spm_pkg::PI_Q62 >> (PHASE_BITS - 1)) * 64'(rem);
    x2   = q62_product(x, x);
    sq   = times127_rounded(taylor_q62(x2, x, 1));
    cq   = times127_rounded(taylor_q62(x2, spm_pkg::Q62_ONE, 0));
    // fold the quarter-wave values out to the full turn
    case (quad)
      spm_pkg::QUAD_0: begin
        s = sq;
        c = cq;
      end
      spm_pkg::QUAD_1: begin
        s = cq;
        c = -sq;
      end
      spm_pkg::QUAD_2: begin
        s = -sq;
        c = -cq;
      end
      default: begin
        s = -cq;
        c = sq;
      end
    endcase
    col.blue  = 8'(128 + s);
    col.green = 8'(128 - c);
    col.red   = 8'(128 - s);
    return col;
  endfunction

  // ---------------------------------------------------------------------------
  // color side: random stall bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      rgb_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rgb_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      rgb_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // color side: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rgb_valid && !rgb_stall) begin
      got_c = '{blue: blue_out, green: green_out, red: red_out};
      if (colors_due.size() == 0) begin
        if (bad_words < 10) begin
          $display("unexpected color word b=%0d g=%0d r=%0d", got_c.blue, got_c.green,
                   got_c.red);
        end
        bad_words++;
      end else begin
        want_c = colors_due.pop_front();
        if (got_c.blue !== want_c.blue || got_c.green !== want_c.green ||
            got_c.red !== want_c.red) begin
          if (bad_words < 10) begin
            $display("color mismatch: want b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     want_c.blue, want_c.green, want_c.red,
                     got_c.blue, got_c.green, got_c.red);
          end
          bad_words++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks, all called at a rising edge and returning at one
  // ---------------------------------------------------------------------------

  // one pixel word, with an optional random gap before it
  task automatic send_pixel(logic [15:0] v);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
    end
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pixel     <= v;
    do @(posedge clk); while (pix_stall);
    // taken at this edge; levels cannot change while words are in flight
    colors_due = {colors_due, map_pixel(v)};
  endtask

  // stop sending and wait for every predicted word
  task automatic drain();
    pix_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle; junk in the upper data bits
  task automatic set_level(spm_pkg::reg_idx_t which, logic [15:0] level);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {16'($urandom), level};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == spm_pkg::REG_LOW_LEVEL) begin
      low_lvl = level;
    end else begin
      high_lvl = level;
    end
    // read back the level just written, address still in place
    @(posedge clk);
    if (prdata !== spm_pkg::DATA_BITS'(level)) begin
      if (bad_words < 10) begin
        $display("level readback mismatch: want %0d, got %0d", level, prdata);
      end
      bad_words++;
    end
  endtask

  task automatic set_window(logic [15:0] lo, logic [15:0] hi);
    drain();
    set_level(spm_pkg::REG_LOW_LEVEL, lo);
    set_level(spm_pkg::REG_HIGH_LEVEL, hi);
  endtask

  // mostly around the window so the clamps and all quadrants are hit
  function automatic logic [15:0] pick_pixel();
    int lo;
    int hi;
    int span;
    int v;
    lo = int'(low_lvl);
    hi = int'(high_lvl);
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom);
    end
    span = (hi > lo) ? hi - lo : 64;
    v = lo - span / 8 - 1 + int'($urandom_range(0, span + span / 4 + 2));
    if (v < 0) begin
      v = 0;
    end
    if (v > 65535) begin
      v = 65535;
    end
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // levels straight out of reset: full 16-bit window
  task automatic test_default_levels();
    send_pixel(16'd0);
    send_pixel(16'd65535);
    send_pixel(16'd65534);
    send_pixel(16'd1);
    send_pixel(16'd16384);
    send_pixel(16'd32768);
    send_pixel(16'd49152);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
  endtask

  // empty and inverted windows give phase zero for any pixel
  task automatic test_empty_range();
    set_window(16'd1000, 16'd1000);
    send_pixel(16'd0);
    send_pixel(16'd1000);
    send_pixel(16'd65535);
    set_window(16'd60000, 16'd100);
    send_pixel(16'd100);
    send_pixel(16'd60001);
  endtask

  // window of 1024: below, at and past both ends, and quadrant boundaries
  task automatic test_window_clamp();
    set_window(16'd100, 16'd1124);
    send_pixel(16'd0);
    send_pixel(16'd99);
    send_pixel(16'd100);
    send_pixel(16'd356);
    send_pixel(16'd612);
    send_pixel(16'd868);
    send_pixel(16'd1123);
    send_pixel(16'd1124);
    send_pixel(16'd65535);
  endtask

  // a run of windows, extremes first, then random ones
  task automatic test_random_levels();
    int lo;
    int hi;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          lo = 0;
          hi = 65535;
        end
        1: begin
          lo = 65535;
          hi = 0;
        end
        2: begin
          lo = 0;
          hi = 1;
        end
        3: begin
          lo = 65534;
          hi = 65535;
        end
        4: begin
          lo = 0;
          hi = 1024;
        end
        5, 6: begin
          // narrow window, fewer steps than phase codes
          lo = $urandom_range(0, 65000);
          hi = lo + $urandom_range(1, 300);
        end
        7: begin
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, 65535);
        end
        default: begin
          lo = $urandom_range(0, 60000);
          hi = $urandom_range(lo + 1, 65535);
        end
      endcase
      set_window(16'(lo), 16'(hi));
      repeat (140) send_pixel(pick_pixel());
    end
  endtask

  // sender holds off until the block has handed back every word
  task automatic test_pause_until_drained();
    set_window(16'($urandom_range(0, 30000)), 16'($urandom_range(30001, 65535)));
    repeat (30) send_pixel(pick_pixel());
    drain();
    repeat (30) send_pixel(pick_pixel());
  endtask

  // last part: back to back words with no idling on either side
  task automatic test_full_rate();
    idle_on <= 1'b0;
    set_window(16'($urandom_range(0, 20000)), 16'($urandom_range(20001, 65535)));
    repeat (100) send_pixel(pick_pixel());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    @(posedge clk);

    test_default_levels();
    test_empty_range();
    test_window_clamp();
    test_random_levels();
    test_pause_until_drained();
    test_full_rate();

    // wait out the pipeline, bounded, and watch for stray words
    pix_valid <= 1'b0;
    waited = 0;
    while (colors_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    leftover = colors_due.size();
    if (leftover != 0) begin
      $display("%0d color words never arrived", leftover);
    end

    if (bad_words == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard limit, far above the slowest correct run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/spm_pkg.sv
hw/rtl/spm_regs.sv
hw/rtl/spm_div_step.sv
hw/rtl/spm_trig_rom.sv
hw/rtl/sine_pseudocolor_mapper.sv
verif/tb_top.sv
